@@ hw/rtl/exclusive_time_profiler_unit_defines.svh @@
// Assertion macros for the exclusive time profiler checker.
`ifndef EXCLUSIVE_TIME_PROFILER_UNIT_DEFINES_SVH
`define EXCLUSIVE_TIME_PROFILER_UNIT_DEFINES_SVH

// Check on every clock edge outside reset.
`define ETP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check on every clock edge, reset included.
`define ETP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hw/rtl/etp_pkg.sv @@
package etp_pkg;

    localparam int ETP_MAX_FUNCS   = 256;
    localparam int ETP_STACK_DEPTH = 64;

    localparam int ID_W   = 8;
    localparam int TIME_W = 32;
    localparam int OP_W   = 2;
    localparam int STS_W  = 2;
    localparam int NF_W   = 9;

    localparam logic [NF_W-1:0] NF_RESET = 9'd256;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_END   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd2;
    localparam logic [STS_W-1:0] STS_RANGE = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

endpackage

@@ hw/rtl/etp_ctrl.sv @@
module etp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output etp_pkg::t_cmd o_cmd
);
    import etp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        w_out_free  = !r_out_valid || !i_out_stall;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/etp_dp.sv @@
module etp_dp #(
    parameter int MAX_FUNCS   = etp_pkg::ETP_MAX_FUNCS,
    parameter int STACK_DEPTH = etp_pkg::ETP_STACK_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  etp_pkg::t_cmd               i_cmd,
    input  logic                        i_cfg_valid,
    input  logic [etp_pkg::NF_W-1:0]    i_cfg_data,
    input  logic [etp_pkg::OP_W-1:0]    i_opcode,
    input  logic [etp_pkg::ID_W-1:0]    i_func_id,
    input  logic [etp_pkg::TIME_W-1:0]  i_timestamp,
    output logic [etp_pkg::ID_W-1:0]    o_charged_id,
    output logic [etp_pkg::TIME_W-1:0]  o_total_time,
    output logic                        o_charged,
    output logic [etp_pkg::STS_W-1:0]   o_status
);
    import etp_pkg::*;

    localparam int TOT_DEPTH = (MAX_FUNCS < (1 << ID_W)) ? MAX_FUNCS : (1 << ID_W);
    localparam int TAW       = (TOT_DEPTH > 1) ? $clog2(TOT_DEPTH) : 1;
    localparam int SAW       = $clog2(STACK_DEPTH);
    localparam int CW        = $clog2(STACK_DEPTH + 1);

    logic [TIME_W-1:0]  r_tot_mem [TOT_DEPTH];
    logic               r_tot_vld [TOT_DEPTH];
    logic [ID_W-1:0]    r_stk_mem [STACK_DEPTH];

    logic [NF_W-1:0]    r_num_funcs;
    logic [CW-1:0]      r_count;
    logic [ID_W-1:0]    r_top;
    logic [TIME_W:0]    r_last;

    logic [OP_W-1:0]    r_op;
    logic [ID_W-1:0]    r_id;
    logic [TIME_W-1:0]  r_t;
    logic [STS_W-1:0]   r_req_status;
    logic [TIME_W:0]    r_delta;
    logic               r_do_chg;
    logic [TIME_W-1:0]  r_tot_q;
    logic               r_vld_q;
    logic [ID_W-1:0]    r_stk_q;

    logic [ID_W-1:0]    r_out_id;
    logic [TIME_W-1:0]  r_out_total;
    logic               r_out_charged;
    logic [STS_W-1:0]   r_out_status;

    logic               w_id_ok;
    logic               w_top_ok;
    logic               w_full;
    logic               w_empty;
    logic               w_known_op;
    logic [STS_W-1:0]   w_status;
    logic [TIME_W:0]    w_end_tick;
    logic [TIME_W+1:0]  w_diff;
    logic [TIME_W:0]    w_delta;
    logic [TAW-1:0]     w_tot_ra;
    logic [SAW-1:0]     w_stk_ra;
    logic [TIME_W-1:0]  w_cur;
    logic [TIME_W+1:0]  w_sum;
    logic [TIME_W-1:0]  w_sat;
    logic               w_ok;

    always_comb begin
        w_id_ok    = ({1'b0, i_func_id} < r_num_funcs) && (int'(i_func_id) < MAX_FUNCS);
        w_top_ok   = int'(r_top) < MAX_FUNCS;
        w_full     = r_count == CW'(STACK_DEPTH);
        w_empty    = r_count == '0;
        w_known_op = (i_opcode == OP_START) || (i_opcode == OP_END) || (i_opcode == OP_READ);
        if (w_known_op && !w_id_ok) begin
            w_status = STS_RANGE;
        end else if ((i_opcode == OP_START) && w_full) begin
            w_status = STS_FULL;
        end else if ((i_opcode == OP_END) && w_empty) begin
            w_status = STS_EMPTY;
        end else begin
            w_status = STS_OK;
        end
        w_end_tick = (i_opcode == OP_END) ? ({1'b0, i_timestamp} + (TIME_W+1)'(1))
                                          : {1'b0, i_timestamp};
        w_diff     = {1'b0, w_end_tick} - {1'b0, r_last};
        w_delta    = w_diff[TIME_W+1] ? '0 : w_diff[TIME_W:0];
        w_tot_ra   = TAW'((i_opcode == OP_READ) ? i_func_id : r_top);
        w_stk_ra   = SAW'(r_count - CW'(2));

        w_cur = r_vld_q ? r_tot_q : '0;
        w_sum = {2'b00, w_cur} + {1'b0, r_delta};
        w_sat = (|w_sum[TIME_W+1:TIME_W]) ? '1 : w_sum[TIME_W-1:0];
        w_ok  = r_req_status == STS_OK;
    end

    // Decode and memory reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op         <= i_opcode;
            r_id         <= i_func_id;
            r_t          <= i_timestamp;
            r_req_status <= w_status;
            r_delta      <= w_delta;
            r_do_chg     <= (w_status == STS_OK) && !w_empty && w_top_ok
                            && ((i_opcode == OP_START) || (i_opcode == OP_END));
            r_tot_q      <= r_tot_mem[w_tot_ra];
            r_vld_q      <= r_tot_vld[w_tot_ra];
            r_stk_q      <= r_stk_mem[w_stk_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_do_chg) begin
            r_tot_mem[TAW'(r_top)] <= w_sat;
        end
        if (i_cmd.commit && w_ok && (r_op == OP_START)) begin
            r_stk_mem[SAW'(r_count)] <= r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TOT_DEPTH; i++) begin
                r_tot_vld[i] <= 1'b0;
            end
        end else if (i_cmd.commit && r_do_chg) begin
            r_tot_vld[TAW'(r_top)] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_funcs <= NF_RESET;
            r_count     <= '0;
            r_top       <= '0;
            r_last      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_num_funcs <= i_cfg_data;
            end
            if (i_cmd.commit && w_ok && (r_op == OP_START)) begin
                r_count <= r_count + CW'(1);
                r_top   <= r_id;
                r_last  <= {1'b0, r_t};
            end else if (i_cmd.commit && w_ok && (r_op == OP_END)) begin
                r_count <= r_count - CW'(1);
                r_top   <= r_stk_q;
                r_last  <= {1'b0, r_t} + (TIME_W+1)'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= r_req_status;
            if (r_do_chg) begin
                r_out_id      <= r_top;
                r_out_total   <= w_sat;
                r_out_charged <= 1'b1;
            end else if (w_ok && (r_op == OP_READ)) begin
                r_out_id      <= r_id;
                r_out_total   <= w_cur;
                r_out_charged <= 1'b1;
            end else begin
                r_out_id      <= '0;
                r_out_total   <= '0;
                r_out_charged <= 1'b0;
            end
        end
    end

    assign o_charged_id = r_out_id;
    assign o_total_time = r_out_total;
    assign o_charged    = r_out_charged;
    assign o_status     = r_out_status;

endmodule

@@ hw/rtl/exclusive_time_profiler_unit.sv @@
// Exclusive time profiler: each request has a decode step and a write step.
// In the decode step, the request is decoded and the accumulator and call
// stack memories are read; in the write step, the saturating add is done, the
// accumulator entry and the stack are written and the result register is
// loaded. The next request is taken in the cycle after that, not earlier,
// due to the read-modify-write of the accumulator memory. The result register
// holds a finished result while the next request is already taken; the write
// step waits only while that register is still full and stalled. Accumulators
// start at zero after reset through per-entry valid bits, so no clearing pass
// is needed and the block takes requests right after reset.
module exclusive_time_profiler_unit #(
    parameter int MAX_FUNCS   = etp_pkg::ETP_MAX_FUNCS,
    parameter int STACK_DEPTH = etp_pkg::ETP_STACK_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [etp_pkg::OP_W-1:0]    i_opcode,
    input  logic [etp_pkg::ID_W-1:0]    i_func_id,
    input  logic [etp_pkg::TIME_W-1:0]  i_timestamp,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [etp_pkg::ID_W-1:0]    o_charged_id,
    output logic [etp_pkg::TIME_W-1:0]  o_total_time,
    output logic                        o_charged,
    output logic [etp_pkg::STS_W-1:0]   o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [etp_pkg::NF_W-1:0]    i_cfg_data
);
    import etp_pkg::*;

    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    etp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    etp_dp #(
        .MAX_FUNCS   (MAX_FUNCS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_opcode     (i_opcode),
        .i_func_id    (i_func_id),
        .i_timestamp  (i_timestamp),
        .o_charged_id (o_charged_id),
        .o_total_time (o_total_time),
        .o_charged    (o_charged),
        .o_status     (o_status)
    );

endmodule

@@ hw/rtl/etp_checker.sv @@
`include "exclusive_time_profiler_unit_defines.svh"

module etp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [etp_pkg::ID_W-1:0]    o_charged_id,
    input logic [etp_pkg::TIME_W-1:0]  o_total_time,
    input logic                        o_charged,
    input logic [etp_pkg::STS_W-1:0]   o_status
);
    import etp_pkg::*;

    `ETP_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_charged_id) && $stable(o_total_time) && $stable(o_charged) && $stable(o_status), "stalled result changed")

    `ETP_ASSERT(a_one_in_flight, i_in_valid && !o_in_stall |=> o_in_stall, "request taken while one is in flight")

    `ETP_ASSERT(a_flag_no_charge, o_out_valid && (o_status != STS_OK) |-> !o_charged && (o_total_time == '0) && (o_charged_id == '0), "flagged result carries a charge")

    `ETP_ASSERT_RST(a_rst_clears, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind exclusive_time_profiler_unit etp_checker u_etp_checker (.*);
